FILE: rtl/api_frame_receiver_assert.svh
// Assertion macros for the frame receiver.
`ifndef API_FRAME_RECEIVER_ASSERT_SVH
`define API_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define AFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AFR_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AFR_ASSERT(label, prop, msg)
`define AFR_ASSERT_ANY(label, prop, msg)

`endif

`endif

FILE: rtl/afr_pkg.sv
`default_nettype none

package afr_pkg;

  // Byte positions inside a frame
  localparam int unsigned IDX_W = 17;
  localparam logic [IDX_W-1:0] IDX_START  = 17'd0;
  localparam logic [IDX_W-1:0] IDX_LEN_HI = 17'd1;
  localparam logic [IDX_W-1:0] IDX_LEN_LO = 17'd2;
  localparam logic [IDX_W-1:0] IDX_TYPE   = 17'd3;
  localparam logic [IDX_W-1:0] IDX_ID     = 17'd4;

  // Bytes outside the length field: delimiter, two length bytes, checksum
  localparam logic [IDX_W:0] FRAME_OVERHEAD = 18'd4;
  localparam logic [7:0]     SUM_GOOD       = 8'hFF;

  // Register map
  localparam int unsigned    REG_IDX_W         = 2;
  localparam logic [REG_IDX_W-1:0] REG_START_DELIM = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AT_TYPE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_TYPE = 2'd2;

  localparam logic [7:0] START_DELIM_RST = 8'h7E;
  localparam logic [7:0] AT_TYPE_RST     = 8'h88;
  localparam logic [7:0] SECOND_TYPE_RST = 8'h9F;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_START    = 3'd1,
    ST_LEN_MISMATCH = 3'd2,
    ST_BAD_SUM      = 3'd3,
    ST_TOO_SHORT    = 3'd4
  } afr_status_t;

  typedef enum logic [1:0] {
    CL_INVALID = 2'd0,
    CL_AT_RESP = 2'd1,
    CL_SECOND  = 2'd2
  } afr_class_t;

endpackage

`default_nettype wire

FILE: rtl/api_frame_receiver.sv
`default_nettype none

// Channel  Dir  Handshake              Contents
// in_      in   in_tvalid/in_tready    tdata: received byte; tlast: checksum byte
// out_     out  out_tvalid/out_tready  tdata: payload byte and frame report; tuser: payload flag
// cfg_     in   APB, pready tied high  start delimiter, AT type, second type
//
// One byte per clock while in_tready is high: each beat is decoded by a single layer
// of logic into the frame state and the output register, so back-to-back beats are taken.
// A beat yields at most one output beat, presented in the cycle after acceptance.
// in_tready drops only while the output register holds a beat that out_tready
// refuses; the output register then holds until taken.
// Reset is synchronous: configuration registers return to their defaults, frame state to zero.

`include "api_frame_receiver_assert.svh"

module api_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tlast,   // end_of_frame
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] payload_byte, [10:8] frame_status, [12:11] frame_class,
  // [20:13] type byte, [28:21] frame_id_out, [44:29] length_field_out, [47:45] zero
  output logic [47:0]      out_tdata,
  output logic             out_tlast,  // frame_done
  output logic             out_tuser,  // payload_valid
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned IW = afr_pkg::IDX_W;

  // configuration registers
  logic [7:0] start_delim_r;
  logic [7:0] at_type_r;
  logic [7:0] second_type_r;

  // frame state
  logic [IW-1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [15:0]   len_r, len_nxt;
  logic          start_ok_r, start_ok_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [7:0]    held_byte_r, held_byte_nxt;
  logic          held_valid_r, held_valid_nxt;

  // output register
  logic                out_valid_r;
  logic                res_valid;
  logic                out_pv_r, res_pv;
  logic [7:0]          out_pb_r, res_pb;
  logic                out_done_r, res_done;
  afr_pkg::afr_status_t out_status_r, res_status;
  afr_pkg::afr_class_t  out_class_r, res_class;
  logic [7:0]          out_type_r, res_type;
  logic [7:0]          out_id_r, res_id;
  logic [15:0]         out_len_r, res_len;

  logic                 in_fire;
  logic                 cfg_wr;
  logic [IW:0]          count;
  logic [IW:0]          len_plus;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= afr_pkg::START_DELIM_RST;
      at_type_r     <= afr_pkg::AT_TYPE_RST;
      second_type_r <= afr_pkg::SECOND_TYPE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        afr_pkg::REG_START_DELIM: start_delim_r <= cfg_pwdata[7:0];
        afr_pkg::REG_AT_TYPE:     at_type_r     <= cfg_pwdata[7:0];
        afr_pkg::REG_SECOND_TYPE: second_type_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      afr_pkg::REG_START_DELIM: cfg_prdata = {24'd0, start_delim_r};
      afr_pkg::REG_AT_TYPE:     cfg_prdata = {24'd0, at_type_r};
      afr_pkg::REG_SECOND_TYPE: cfg_prdata = {24'd0, second_type_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- byte decode
  assign count    = {1'b0, byte_idx_r} + {{IW{1'b0}}, 1'b1};

  always_comb begin
    start_ok_nxt   = start_ok_r;
    len_nxt        = len_r;
    sum_nxt        = sum_r;
    type_nxt       = type_r;
    id_nxt         = id_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    byte_idx_nxt   = byte_idx_r;

    if (byte_idx_r == afr_pkg::IDX_START)  start_ok_nxt = (in_tdata == start_delim_r);
    if (byte_idx_r == afr_pkg::IDX_LEN_HI) len_nxt = {in_tdata, 8'd0};
    if (byte_idx_r == afr_pkg::IDX_LEN_LO) len_nxt = {len_r[15:8], in_tdata};
    if (byte_idx_r >= afr_pkg::IDX_TYPE)   sum_nxt = sum_r + in_tdata;
    if (byte_idx_r == afr_pkg::IDX_TYPE)   type_nxt = in_tdata;
    if (byte_idx_r == afr_pkg::IDX_ID)     id_nxt = in_tdata;

    // compare against the captured length before the frame context is dropped
    len_plus = {{(IW-15){1'b0}}, len_nxt} + afr_pkg::FRAME_OVERHEAD;

    res_pv     = 1'b0;
    res_pb     = 8'd0;
    res_done   = 1'b0;
    res_status = afr_pkg::ST_OK;
    res_class  = afr_pkg::CL_INVALID;
    res_type   = 8'd0;
    res_id     = 8'd0;
    res_len    = 16'd0;

    if (in_tlast) begin
      res_pv   = held_valid_r;
      res_pb   = held_valid_r ? held_byte_r : 8'd0;
      res_done = 1'b1;
      priority if (!start_ok_nxt)                    res_status = afr_pkg::ST_BAD_START;
      else if (byte_idx_r < afr_pkg::IDX_ID)         res_status = afr_pkg::ST_TOO_SHORT;
      else if (len_plus != count)                    res_status = afr_pkg::ST_LEN_MISMATCH;
      else if (sum_nxt != afr_pkg::SUM_GOOD)         res_status = afr_pkg::ST_BAD_SUM;
      else                                           res_status = afr_pkg::ST_OK;
      if (byte_idx_r >= afr_pkg::IDX_TYPE) begin
        priority if (type_nxt == at_type_r)    res_class = afr_pkg::CL_AT_RESP;
        else if (type_nxt == second_type_r)    res_class = afr_pkg::CL_SECOND;
        else                                   res_class = afr_pkg::CL_INVALID;
      end
      res_type = type_nxt;
      res_id   = id_nxt;
      res_len  = len_nxt;
      // drop the whole frame context
      start_ok_nxt   = 1'b0;
      len_nxt        = 16'd0;
      sum_nxt        = 8'd0;
      type_nxt       = 8'd0;
      id_nxt         = 8'd0;
      held_byte_nxt  = 8'd0;
      held_valid_nxt = 1'b0;
      byte_idx_nxt   = '0;
    end else begin
      if (byte_idx_r >= afr_pkg::IDX_ID) begin
        res_pv         = held_valid_r;
        res_pb         = held_valid_r ? held_byte_r : 8'd0;
        held_byte_nxt  = in_tdata;
        held_valid_nxt = 1'b1;
      end
      // saturate on overlong frames
      if (byte_idx_r != '1) byte_idx_nxt = count[IW-1:0];
    end

    res_valid = res_pv || res_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r   <= '0;
      sum_r        <= 8'd0;
      len_r        <= 16'd0;
      start_ok_r   <= 1'b0;
      type_r       <= 8'd0;
      id_r         <= 8'd0;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
    end else if (in_fire) begin
      byte_idx_r   <= byte_idx_nxt;
      sum_r        <= sum_nxt;
      len_r        <= len_nxt;
      start_ok_r   <= start_ok_nxt;
      type_r       <= type_nxt;
      id_r         <= id_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload of the output beat; hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pv_r     <= res_pv;
      out_pb_r     <= res_pb;
      out_done_r   <= res_done;
      out_status_r <= res_status;
      out_class_r  <= res_class;
      out_type_r   <= res_type;
      out_id_r     <= res_id;
      out_len_r    <= res_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_pv_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {3'd0, out_len_r, out_id_r, out_type_r,
                       out_class_r, out_status_r, out_pb_r};

  // ---------------------------------------------------------------- checks
  `AFR_ASSERT_ANY(a_reset_clears,
    !rst_n |=> (byte_idx_r == '0 && !out_valid_r && !held_valid_r),
    "reset left frame state or output beat behind")
  `AFR_ASSERT(a_end_clears_frame,
    (in_fire && in_tlast) |=> (byte_idx_r == '0 && !held_valid_r && sum_r == 8'd0),
    "frame context not dropped after end beat")
  `AFR_ASSERT(a_held_implies_payload_idx,
    held_valid_r |-> (byte_idx_r > afr_pkg::IDX_ID),
    "held byte present before payload position")
  `AFR_ASSERT(a_out_beat_has_content,
    out_valid_r |-> (out_pv_r || out_done_r),
    "empty output beat presented")
  `AFR_ASSERT(a_report_only_on_end,
    (out_valid_r && !out_done_r) |-> (out_status_r == afr_pkg::ST_OK &&
      out_class_r == afr_pkg::CL_INVALID && out_len_r == 16'd0),
    "frame report on a non-final beat")

endmodule

`default_nettype wire

FILE: test/tb_api_frame_receiver.sv
`timescale 1ns / 1ps

module tb_api_frame_receiver;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MIN_FRAME     = 5;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam logic [afr_pkg::IDX_W-1:0] IDX_SAT = '1;

  typedef struct {
    logic                 pay_valid;
    logic [7:0]           pay_byte;
    logic                 done;
    afr_pkg::afr_status_t status;
    afr_pkg::afr_class_t  cls;
    logic [7:0]           ftype;
    logic [7:0]           fid;
    logic [15:0]          flen;
  } rx_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [47:0] out_tdata;
  wire         out_tlast;
  wire         out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'h0;
  logic [31:0] cfg_pwdata = 32'h0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  // shadow of the register file and the frame being received
  logic [7:0]                 delim_cfg = afr_pkg::START_DELIM_RST;
  logic [7:0]                 at_cfg = afr_pkg::AT_TYPE_RST;
  logic [7:0]                 second_cfg = afr_pkg::SECOND_TYPE_RST;
  logic [afr_pkg::IDX_W-1:0]  byte_pos = '0;
  logic [7:0]                 running_sum = 8'h00;
  logic [15:0]                len_seen = 16'h0000;
  logic                       delim_seen_ok = 1'b0;
  logic [7:0]                 type_seen = 8'h00;
  logic [7:0]                 id_seen = 8'h00;
  logic [7:0]                 held_data = 8'h00;
  logic                       held_full = 1'b0;

  rx_report_t pending_reports[$];

  int mismatches = 0;
  int beats_checked = 0;
  int frames_closed = 0;
  int frames_ok = 0;
  int bytes_sent = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_idle_pct = 0;

  api_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Work out what one accepted byte produces and queue it.
  function automatic void predict_beat(input logic [7:0] b, input logic last);
    rx_report_t               r;
    logic [afr_pkg::IDX_W:0]  count;
    r.pay_valid = 1'b0;
    r.pay_byte  = 8'h00;
    r.done      = 1'b0;
    r.status    = afr_pkg::ST_OK;
    r.cls       = afr_pkg::CL_INVALID;
    r.ftype     = 8'h00;
    r.fid       = 8'h00;
    r.flen      = 16'h0000;
    if (byte_pos == afr_pkg::IDX_START) delim_seen_ok = (b == delim_cfg);
    if (byte_pos == afr_pkg::IDX_LEN_HI) len_seen = {b, 8'h00};
    if (byte_pos == afr_pkg::IDX_LEN_LO) len_seen[7:0] = b;
    if (byte_pos >= afr_pkg::IDX_TYPE) running_sum += b;
    if (byte_pos == afr_pkg::IDX_TYPE) type_seen = b;
    if (byte_pos == afr_pkg::IDX_ID) id_seen = b;
    if (last) begin
      count       = byte_pos + 1'b1;
      r.pay_valid = held_full;
      r.pay_byte  = held_full ? held_data : 8'h00;
      r.done      = 1'b1;
      if (!delim_seen_ok) r.status = afr_pkg::ST_BAD_START;
      else if (count < MIN_FRAME) r.status = afr_pkg::ST_TOO_SHORT;
      else if (len_seen + afr_pkg::FRAME_OVERHEAD != count)
        r.status = afr_pkg::ST_LEN_MISMATCH;
      else if (running_sum != afr_pkg::SUM_GOOD) r.status = afr_pkg::ST_BAD_SUM;
      // the type byte only counts once it has actually arrived
      if (count > afr_pkg::IDX_TYPE) begin
        if (type_seen == at_cfg) r.cls = afr_pkg::CL_AT_RESP;
        else if (type_seen == second_cfg) r.cls = afr_pkg::CL_SECOND;
      end
      r.ftype       = type_seen;
      r.fid         = id_seen;
      r.flen        = len_seen;
      byte_pos      = '0;
      running_sum   = 8'h00;
      len_seen      = 16'h0000;
      delim_seen_ok = 1'b0;
      type_seen     = 8'h00;
      id_seen       = 8'h00;
      held_data     = 8'h00;
      held_full     = 1'b0;
    end else begin
      if (byte_pos >= afr_pkg::IDX_ID) begin
        r.pay_valid = held_full;
        r.pay_byte  = held_full ? held_data : 8'h00;
        held_data   = b;
        held_full   = 1'b1;
      end
      if (byte_pos != IDX_SAT) byte_pos++;
    end
    if (r.pay_valid || r.done) pending_reports.insert(pending_reports.size(), r);
  endfunction

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("MISMATCH %s at result beat %0d: expected 0x%0h, got 0x%0h",
                 name, beats_checked, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rx_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("MISMATCH unexpected result beat: tdata 0x%h tlast %b tuser %b",
                   out_tdata, out_tlast, out_tuser);
      end else begin
        want = pending_reports.pop_front();
        check_field("payload_valid", want.pay_valid, out_tuser);
        check_field("payload_byte", want.pay_byte, out_tdata[7:0]);
        check_field("frame_done", want.done, out_tlast);
        check_field("frame_status", want.status, out_tdata[10:8]);
        check_field("frame_class", want.cls, out_tdata[12:11]);
        check_field("type byte", want.ftype, out_tdata[20:13]);
        check_field("frame_id", want.fid, out_tdata[28:21]);
        check_field("length_field", want.flen, out_tdata[44:29]);
        check_field("tdata padding", 48'h0, out_tdata[47:45]);
        if (want.done) begin
          frames_closed++;
          if (want.status == afr_pkg::ST_OK) frames_ok++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] f[$]);
    int k;
    for (k = 0; k < f.size(); k++) send_byte(f[k], k == f.size() - 1);
  endtask

  function automatic void add_checksum(inout logic [7:0] f[$], input logic good);
    logic [7:0] sum;
    logic [7:0] flip;
    int         k;
    sum = 8'h00;
    for (k = afr_pkg::IDX_TYPE; k < f.size(); k++) sum += f[k];
    flip = good ? 8'h00 : 8'($urandom_range(1, 255));
    f.insert(f.size(), (afr_pkg::SUM_GOOD - sum) ^ flip);
  endfunction

  // n_data counts the bytes between the length field and the checksum
  function automatic void make_frame(output logic [7:0] f[$], input logic [7:0] delim,
                                     input logic [15:0] len_field, input int n_data,
                                     input logic [7:0] ftype, input logic good_sum);
    int k;
    f.delete();
    f.insert(f.size(), delim);
    f.insert(f.size(), len_field[15:8]);
    f.insert(f.size(), len_field[7:0]);
    for (k = 0; k < n_data; k++) f.insert(f.size(), (k == 0) ? ftype : 8'($urandom));
    add_checksum(f, good_sum);
  endfunction

  // Drop valid, drain every expected beat, then let the pipeline settle.
  task automatic wait_idle;
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_read(input logic [afr_pkg::REG_IDX_W-1:0] idx, output logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [afr_pkg::REG_IDX_W-1:0] idx, input logic [7:0] value);
    logic [31:0] junk;
    logic [31:0] got;
    junk = $urandom;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    // upper bits are don't-care on write
    cfg_pwdata  <= {junk[31:8], value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      afr_pkg::REG_START_DELIM: delim_cfg = value;
      afr_pkg::REG_AT_TYPE:     at_cfg = value;
      afr_pkg::REG_SECOND_TYPE: second_cfg = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_read(idx, got);
    check_field("register readback", {24'h0, value}, got);
  endtask

  task automatic test_reset_values;
    logic [31:0] got;
    cfg_read(afr_pkg::REG_START_DELIM, got);
    check_field("start delimiter after reset", {24'h0, afr_pkg::START_DELIM_RST}, got);
    cfg_read(afr_pkg::REG_AT_TYPE, got);
    check_field("AT type after reset", {24'h0, afr_pkg::AT_TYPE_RST}, got);
    cfg_read(afr_pkg::REG_SECOND_TYPE, got);
    check_field("second type after reset", {24'h0, afr_pkg::SECOND_TYPE_RST}, got);
  endtask

  task automatic test_short_frames;
    send_byte(delim_cfg, 1'b1);
    // a wrong delimiter outranks the short length
    send_byte(~delim_cfg, 1'b1);
    send_byte(delim_cfg, 1'b0);
    send_byte(8'h12, 1'b1);
    // four bytes: the end byte doubles as the type and sets the class
    send_byte(delim_cfg, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(at_cfg, 1'b1);
  endtask

  task automatic test_frame_checks;
    logic [7:0] f[$];
    // five bytes: checksum lands in the id, nothing is passed out
    make_frame(f, delim_cfg, 16'd1, 1, second_cfg, 1'b1);
    send_frame(f);
    f.delete();
    f.insert(f.size(), delim_cfg);
    f.insert(f.size(), 8'h00);
    f.insert(f.size(), 8'h04);
    f.insert(f.size(), at_cfg);
    f.insert(f.size(), 8'hFF);
    f.insert(f.size(), 8'h00);
    f.insert(f.size(), 8'hFF);
    add_checksum(f, 1'b1);
    send_frame(f);
    make_frame(f, delim_cfg, 16'hFFFF, 3, at_cfg, 1'b1);
    send_frame(f);
    make_frame(f, delim_cfg, 16'd3, 3, 8'h00, 1'b0);
    send_frame(f);
    make_frame(f, delim_cfg ^ 8'h80, 16'd3, 3, second_cfg, 1'b1);
    send_frame(f);
  endtask

  task automatic test_register_extremes;
    logic [7:0] f[$];
    wait_idle;
    cfg_write(afr_pkg::REG_START_DELIM, 8'h00);
    cfg_write(afr_pkg::REG_AT_TYPE, 8'hFF);
    cfg_write(afr_pkg::REG_SECOND_TYPE, 8'h00);
    make_frame(f, delim_cfg, 16'd2, 2, 8'hFF, 1'b1);
    send_frame(f);
    make_frame(f, delim_cfg, 16'd3, 3, 8'h00, 1'b1);
    send_frame(f);
    wait_idle;
    cfg_write(afr_pkg::REG_START_DELIM, 8'hFF);
    cfg_write(afr_pkg::REG_AT_TYPE, 8'h00);
    cfg_write(afr_pkg::REG_SECOND_TYPE, 8'hFF);
    make_frame(f, delim_cfg, 16'd2, 2, 8'h00, 1'b1);
    send_frame(f);
    make_frame(f, afr_pkg::START_DELIM_RST, 16'd2, 2, 8'hFF, 1'b1);
    send_frame(f);
    wait_idle;
    // equal type registers: AT response takes precedence
    cfg_write(afr_pkg::REG_AT_TYPE, 8'h5A);
    cfg_write(afr_pkg::REG_SECOND_TYPE, 8'h5A);
    make_frame(f, delim_cfg, 16'd4, 4, 8'h5A, 1'b1);
    send_frame(f);
  endtask

  task automatic load_random_config;
    wait_idle;
    cfg_write(afr_pkg::REG_START_DELIM, 8'($urandom));
    cfg_write(afr_pkg::REG_AT_TYPE, 8'($urandom));
    cfg_write(afr_pkg::REG_SECOND_TYPE, ($urandom_range(0, 3) == 0) ? at_cfg : 8'($urandom));
  endtask

  // Mostly well-formed frames with random content; the rest broken or noise.
  task automatic test_random_traffic(input int n_bytes);
    logic [7:0]  f[$];
    logic [7:0]  ftype;
    logic [15:0] lf;
    int          stop_at;
    int          kind;
    int          n;
    int          k;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      case ($urandom_range(0, 2))
        0:       ftype = at_cfg;
        1:       ftype = second_cfg;
        default: ftype = 8'($urandom);
      endcase
      lf = 16'(n);
      if (kind < 70) begin
        make_frame(f, delim_cfg, lf, n, ftype, 1'b1);
        send_frame(f);
      end else if (kind < 78) begin
        make_frame(f, delim_cfg, lf, n, ftype, 1'b0);
        send_frame(f);
      end else if (kind < 84) begin
        case ($urandom_range(0, 2))
          0:       lf = 16'($urandom);
          1:       lf = lf + 16'd1;
          default: lf = lf - 16'd1;
        endcase
        make_frame(f, delim_cfg, lf, n, ftype, 1'b1);
        send_frame(f);
      end else if (kind < 88) begin
        make_frame(f, delim_cfg ^ 8'($urandom_range(1, 255)), lf, n, ftype, 1'b1);
        send_frame(f);
      end else if (kind < 94) begin
        make_frame(f, $urandom_range(0, 1) ? delim_cfg : 8'($urandom), lf, n, ftype, 1'b1);
        k = $urandom_range(1, 4);
        while (f.size() > k) f.delete(f.size() - 1);
        send_frame(f);
      end else begin
        // loose bytes with end markers scattered among them
        k = $urandom_range(1, 8);
        for (n = 0; n < k; n++)
          send_byte(8'($urandom), (n == k - 1) || ($urandom_range(0, 3) == 0));
      end
    end
  endtask

  task automatic test_long_frames;
    logic [7:0] f[$];
    // length field with its high byte in use
    make_frame(f, delim_cfg, 16'h0100, 256, at_cfg, 1'b1);
    send_frame(f);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct  = 15;
    recv_idle_pct = 79;
    test_reset_values;
    test_short_frames;
    test_frame_checks;
    test_register_extremes;
    load_random_config;
    test_random_traffic(320);

    send_gap_pct  = 79;
    recv_idle_pct = 15;
    load_random_config;
    test_random_traffic(340);

    send_gap_pct  = 0;
    recv_idle_pct = 0;
    load_random_config;
    test_random_traffic(320);
    test_long_frames;

    wait_idle;
    $display("Sent %0d bytes; %0d frames closed (%0d clean), %0d result beats checked",
             bytes_sent, frames_closed, frames_ok, beats_checked);
    $display("Short, malformed and long frames, %0d register writes, three stall mixes",
             reg_writes);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
